// ----- design/bc1_pkg.sv -----
// Shared types, constants and helper functions of the BC1 block encoder.
package bc1_pkg;

	localparam int CHAN_W          = 8;
	localparam int COLOR_W         = 16;
	localparam int SEL_W           = 2;
	localparam int PIXELS_PER_BLOCK = 16;
	localparam int CNT_W           = $clog2(PIXELS_PER_BLOCK);
	localparam int SELECTOR_W      = SEL_W * PIXELS_PER_BLOCK;
	localparam int NUM_BANKS       = 2;
	localparam int BANK_W          = $clog2(NUM_BANKS);
	localparam int RAM_AW          = BANK_W + CNT_W;
	localparam int RAM_DEPTH       = 2 ** RAM_AW;
	localparam int QUEUE_DEPTH     = 2;
	localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);
	localparam int NUM_ENTRIES     = 4;
	localparam int DIST_W          = 18;

	localparam logic [CNT_W-1:0]  LAST_PIXEL      = CNT_W'(PIXELS_PER_BLOCK - 1);
	localparam logic [CHAN_W-1:0] THRESHOLD_RESET = 8'd128;
	localparam logic [CHAN_W-1:0] CHAN_MAX        = 8'hFF;
	localparam logic [CHAN_W-1:0] CHAN_MIN        = 8'h00;
	localparam logic [SEL_W-1:0]  IDX_TRANSPARENT = 2'd3;

	// floor(n / 3) for n below 1024 is floor(n * 683 / 2048).
	localparam int DIV3_RECIP = 683;
	localparam int DIV3_SHIFT = 11;

	typedef struct packed {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
		logic [CHAN_W-1:0] alpha;
	} pixel_t;

	localparam int PIXEL_W = $bits(pixel_t);

	typedef struct packed {
		logic [COLOR_W-1:0]    color_a;
		logic [COLOR_W-1:0]    color_b;
		logic [SELECTOR_W-1:0] selector_bits;
	} block_t;

	// One finished block handed from the front end to the back end.
	typedef struct packed {
		logic [CHAN_W-1:0] min_r;
		logic [CHAN_W-1:0] min_g;
		logic [CHAN_W-1:0] min_b;
		logic [CHAN_W-1:0] max_r;
		logic [CHAN_W-1:0] max_g;
		logic [CHAN_W-1:0] max_b;
		logic              opaque;
		logic              transp;
		logic [CHAN_W-1:0] threshold;
		logic [BANK_W-1:0] bank;
	} desc_t;

	typedef struct packed {
		logic              en;
		logic [RAM_AW-1:0] addr;
		pixel_t            data;
	} ram_wr_t;

	typedef struct packed {
		logic              en;
		logic [RAM_AW-1:0] addr;
	} ram_rd_t;

	typedef struct packed {
		logic              valid;
		logic [BANK_W-1:0] bank;
	} bank_rel_t;

	typedef struct packed {
		logic valid;
		logic full;
	} queue_stat_t;

	function automatic logic [COLOR_W-1:0] pack565(input logic [CHAN_W-1:0] r,
			input logic [CHAN_W-1:0] g, input logic [CHAN_W-1:0] b);
		return {r[7:3], g[7:2], b[7:3]};
	endfunction

	// floor(v * 255 / 31)
	function automatic logic [CHAN_W-1:0] expand5(input logic [4:0] v);
		logic [CHAN_W-1:0] e;
		case (v)
			5'd0:  e = 8'd0;   5'd1:  e = 8'd8;   5'd2:  e = 8'd16;  5'd3:  e = 8'd24;
			5'd4:  e = 8'd32;  5'd5:  e = 8'd41;  5'd6:  e = 8'd49;  5'd7:  e = 8'd57;
			5'd8:  e = 8'd65;  5'd9:  e = 8'd74;  5'd10: e = 8'd82;  5'd11: e = 8'd90;
			5'd12: e = 8'd98;  5'd13: e = 8'd106; 5'd14: e = 8'd115; 5'd15: e = 8'd123;
			5'd16: e = 8'd131; 5'd17: e = 8'd139; 5'd18: e = 8'd148; 5'd19: e = 8'd156;
			5'd20: e = 8'd164; 5'd21: e = 8'd172; 5'd22: e = 8'd180; 5'd23: e = 8'd189;
			5'd24: e = 8'd197; 5'd25: e = 8'd205; 5'd26: e = 8'd213; 5'd27: e = 8'd222;
			5'd28: e = 8'd230; 5'd29: e = 8'd238; 5'd30: e = 8'd246; 5'd31: e = 8'd255;
			default: e = 8'd0;
		endcase
		return e;
	endfunction

	// floor(v * 255 / 63) = 4v + floor(v / 21)
	function automatic logic [CHAN_W-1:0] expand6(input logic [5:0] v);
		logic [CHAN_W-1:0] q;
		q = CHAN_W'(v >= 6'd21) + CHAN_W'(v >= 6'd42) + CHAN_W'(v == 6'd63);
		return {v, 2'b00} + q;
	endfunction

	function automatic logic [CHAN_W-1:0] div3(input logic [9:0] n);
		logic [19:0] p;
		p = 20'(n) * 20'(DIV3_RECIP);
		return p[DIV3_SHIFT +: CHAN_W];
	endfunction

	function automatic logic [CHAN_W-1:0] mid2(input logic [CHAN_W-1:0] a,
			input logic [CHAN_W-1:0] b);
		logic [CHAN_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[CHAN_W:1];
	endfunction

	// (2a + b) / 3
	function automatic logic [CHAN_W-1:0] third(input logic [CHAN_W-1:0] a,
			input logic [CHAN_W-1:0] b);
		logic [9:0] s;
		s = {1'b0, a, 1'b0} + {2'b00, b};
		return div3(s);
	endfunction

	function automatic logic [2*CHAN_W-1:0] sqdiff(input logic [CHAN_W-1:0] a,
			input logic [CHAN_W-1:0] b);
		logic [CHAN_W-1:0] d;
		d = (a >= b) ? (a - b) : (b - a);
		return {{CHAN_W{1'b0}}, d} * {{CHAN_W{1'b0}}, d};
	endfunction

endpackage

// ----- design/bc1_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
module bc1_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- design/bc1_front.sv -----
// Front end: takes pixels into a free RAM bank and tracks the opaque color bounds.
module bc1_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       pixel_valid,
	output logic                       pixel_stall,
	input  bc1_pkg::pixel_t            pixel,
	input  logic [bc1_pkg::CHAN_W-1:0] threshold,
	input  bc1_pkg::bank_rel_t         rel,
	output bc1_pkg::ram_wr_t           ram_wr,
	output logic                       push,
	output bc1_pkg::desc_t             desc
);

	logic [bc1_pkg::CNT_W-1:0]     cnt_q;
	logic [bc1_pkg::BANK_W-1:0]    bank_q;
	logic [bc1_pkg::NUM_BANKS-1:0] busy_q;
	logic [bc1_pkg::CHAN_W-1:0]    min_r_q, min_g_q, min_b_q;
	logic [bc1_pkg::CHAN_W-1:0]    max_r_q, max_g_q, max_b_q;
	logic                          opaque_q, transp_q;

	logic                          accept, is_opaque, last;
	logic [bc1_pkg::CHAN_W-1:0]    n_min_r, n_min_g, n_min_b;
	logic [bc1_pkg::CHAN_W-1:0]    n_max_r, n_max_g, n_max_b;

	assign pixel_stall = busy_q[bank_q];
	assign accept      = pixel_valid && !busy_q[bank_q];
	assign is_opaque   = pixel.alpha >= threshold;
	assign last        = cnt_q == bc1_pkg::LAST_PIXEL;
	assign push        = accept && last;

	assign n_min_r = (is_opaque && pixel.red   < min_r_q) ? pixel.red   : min_r_q;
	assign n_min_g = (is_opaque && pixel.green < min_g_q) ? pixel.green : min_g_q;
	assign n_min_b = (is_opaque && pixel.blue  < min_b_q) ? pixel.blue  : min_b_q;
	assign n_max_r = (is_opaque && pixel.red   > max_r_q) ? pixel.red   : max_r_q;
	assign n_max_g = (is_opaque && pixel.green > max_g_q) ? pixel.green : max_g_q;
	assign n_max_b = (is_opaque && pixel.blue  > max_b_q) ? pixel.blue  : max_b_q;

	always_comb begin
		ram_wr.en   = accept;
		ram_wr.addr = {bank_q, cnt_q};
		ram_wr.data = pixel;

		desc.min_r     = n_min_r;
		desc.min_g     = n_min_g;
		desc.min_b     = n_min_b;
		desc.max_r     = n_max_r;
		desc.max_g     = n_max_g;
		desc.max_b     = n_max_b;
		desc.opaque    = opaque_q | is_opaque;
		desc.transp    = transp_q | !is_opaque;
		desc.threshold = threshold;
		desc.bank      = bank_q;
	end

	// A bank is owned by the back end from the end of its block until its last read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= '0;
		end else begin
			for (int i = 0; i < bc1_pkg::NUM_BANKS; i++) begin
				if (push && bank_q == bc1_pkg::BANK_W'(i)) begin
					busy_q[i] <= 1'b1;
				end else if (rel.valid && rel.bank == bc1_pkg::BANK_W'(i)) begin
					busy_q[i] <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			bank_q   <= '0;
			min_r_q  <= bc1_pkg::CHAN_MAX;
			min_g_q  <= bc1_pkg::CHAN_MAX;
			min_b_q  <= bc1_pkg::CHAN_MAX;
			max_r_q  <= bc1_pkg::CHAN_MIN;
			max_g_q  <= bc1_pkg::CHAN_MIN;
			max_b_q  <= bc1_pkg::CHAN_MIN;
			opaque_q <= 1'b0;
			transp_q <= 1'b0;
		end else if (accept) begin
			cnt_q <= cnt_q + 1'b1;
			if (last) begin
				bank_q   <= bank_q + 1'b1;
				min_r_q  <= bc1_pkg::CHAN_MAX;
				min_g_q  <= bc1_pkg::CHAN_MAX;
				min_b_q  <= bc1_pkg::CHAN_MAX;
				max_r_q  <= bc1_pkg::CHAN_MIN;
				max_g_q  <= bc1_pkg::CHAN_MIN;
				max_b_q  <= bc1_pkg::CHAN_MIN;
				opaque_q <= 1'b0;
				transp_q <= 1'b0;
			end else begin
				min_r_q  <= n_min_r;
				min_g_q  <= n_min_g;
				min_b_q  <= n_min_b;
				max_r_q  <= n_max_r;
				max_g_q  <= n_max_g;
				max_b_q  <= n_max_b;
				opaque_q <= desc.opaque;
				transp_q <= desc.transp;
			end
		end
	end

endmodule

// ----- design/bc1_queue.sv -----
// Small FIFO of finished-block requests between the front end and the back end.
module bc1_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  bc1_pkg::desc_t       push_data,
	input  logic                 pop,
	output bc1_pkg::desc_t       head,
	output bc1_pkg::queue_stat_t stat
);

	bc1_pkg::desc_t              mem_q [bc1_pkg::QUEUE_DEPTH];
	logic [bc1_pkg::QPTR_W-1:0]  wptr_q, rptr_q;
	logic [bc1_pkg::QCNT_W-1:0]  count_q;

	assign head       = mem_q[rptr_q];
	assign stat.valid = count_q != '0;
	assign stat.full  = count_q == bc1_pkg::QCNT_W'(bc1_pkg::QUEUE_DEPTH);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == bc1_pkg::QPTR_W'(bc1_pkg::QUEUE_DEPTH - 1)) ?
					'0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == bc1_pkg::QPTR_W'(bc1_pkg::QUEUE_DEPTH - 1)) ?
					'0 : rptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- design/bc1_back.sv -----
// Back end: builds endpoints and palette, then scans the stored pixels for their indices.
module bc1_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  bc1_pkg::queue_stat_t q_stat,
	input  bc1_pkg::desc_t       head,
	output logic                 pop,
	output bc1_pkg::ram_rd_t     ram_rd,
	input  bc1_pkg::pixel_t      rdata_s1,
	output bc1_pkg::bank_rel_t   rel,
	output logic                 block_valid,
	input  logic                 block_stall,
	output bc1_pkg::block_t      block
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_PAL   = 3'd1;
	localparam logic [2:0] ST_SCAN  = 3'd2;
	localparam logic [2:0] ST_DRAIN = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	logic [2:0]                        state_q;
	logic [bc1_pkg::CNT_W-1:0]         cnt_q;
	logic [bc1_pkg::COLOR_W-1:0]       c0_q, c1_q;
	logic                              mode3_q, opaque_q;
	logic [bc1_pkg::CHAN_W-1:0]        thr_q;
	logic [bc1_pkg::BANK_W-1:0]        bank_q;
	logic [bc1_pkg::CHAN_W-1:0]        pal_r_q [bc1_pkg::NUM_ENTRIES];
	logic [bc1_pkg::CHAN_W-1:0]        pal_g_q [bc1_pkg::NUM_ENTRIES];
	logic [bc1_pkg::CHAN_W-1:0]        pal_b_q [bc1_pkg::NUM_ENTRIES];
	logic [bc1_pkg::SELECTOR_W-1:0]    sel_q;
	logic                              out_valid_q;
	bc1_pkg::block_t                   out_q;

	logic                              valid_s1;
	logic [bc1_pkg::CNT_W-1:0]         idx_s1;
	logic                              valid_s2, transp_s2;
	logic [bc1_pkg::CNT_W-1:0]         idx_s2;
	logic [bc1_pkg::DIST_W-1:0]        dist_s2 [bc1_pkg::NUM_ENTRIES];

	logic [bc1_pkg::COLOR_W-1:0]       ca, cb, c0_n, c1_n;
	logic [bc1_pkg::DIST_W-1:0]        dist_now [bc1_pkg::NUM_ENTRIES];
	logic [bc1_pkg::DIST_W-1:0]        best_d;
	logic [bc1_pkg::SEL_W-1:0]         best_id, pick;
	logic                              load_out;

	assign pop      = (state_q == ST_IDLE) && q_stat.valid;
	assign load_out = (state_q == ST_DONE) && (!out_valid_q || !block_stall);

	assign ram_rd.en   = state_q == ST_SCAN;
	assign ram_rd.addr = {bank_q, cnt_q};
	assign rel.valid   = (state_q == ST_SCAN) && (cnt_q == bc1_pkg::LAST_PIXEL);
	assign rel.bank    = bank_q;

	assign block_valid = out_valid_q;
	assign block       = out_q;

	// Endpoint ordering: the transparent mode wants c0 <= c1, the opaque mode c0 > c1.
	always_comb begin
		ca = bc1_pkg::pack565(head.max_r, head.max_g, head.max_b);
		cb = bc1_pkg::pack565(head.min_r, head.min_g, head.min_b);
		if (head.transp) begin
			c0_n = (ca > cb) ? cb : ca;
			c1_n = (ca > cb) ? ca : cb;
		end else begin
			c0_n = (ca < cb) ? cb : ca;
			c1_n = (ca < cb) ? ca : cb;
			if (ca == cb) begin
				if (ca != '0) begin
					c1_n = ca - 1'b1;
				end else begin
					c0_n = bc1_pkg::COLOR_W'(1);
				end
			end
		end
	end

	always_comb begin
		for (int k = 0; k < bc1_pkg::NUM_ENTRIES; k++) begin
			dist_now[k] = bc1_pkg::DIST_W'(bc1_pkg::sqdiff(rdata_s1.red, pal_r_q[k]))
				+ bc1_pkg::DIST_W'(bc1_pkg::sqdiff(rdata_s1.green, pal_g_q[k]))
				+ bc1_pkg::DIST_W'(bc1_pkg::sqdiff(rdata_s1.blue, pal_b_q[k]));
		end
	end

	// Nearest entry with ties to the lower index; the fourth entry only in opaque mode.
	always_comb begin
		best_d  = dist_s2[0];
		best_id = 2'd0;
		if (dist_s2[1] < best_d) begin
			best_d  = dist_s2[1];
			best_id = 2'd1;
		end
		if (dist_s2[2] < best_d) begin
			best_d  = dist_s2[2];
			best_id = 2'd2;
		end
		if (!mode3_q && dist_s2[3] < best_d) begin
			best_id = 2'd3;
		end
		pick = transp_s2 ? bc1_pkg::IDX_TRANSPARENT : best_id;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			valid_s1 <= state_q == ST_SCAN;
			valid_s2 <= valid_s1;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!block_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						state_q <= ST_PAL;
					end
				end
				ST_PAL: begin
					cnt_q   <= '0;
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == bc1_pkg::LAST_PIXEL) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!valid_s1 && !valid_s2) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			c0_q       <= c0_n;
			c1_q       <= c1_n;
			mode3_q    <= head.transp;
			opaque_q   <= head.opaque;
			thr_q      <= head.threshold;
			bank_q     <= head.bank;
			pal_r_q[0] <= bc1_pkg::expand5(c0_n[15:11]);
			pal_g_q[0] <= bc1_pkg::expand6(c0_n[10:5]);
			pal_b_q[0] <= bc1_pkg::expand5(c0_n[4:0]);
			pal_r_q[1] <= bc1_pkg::expand5(c1_n[15:11]);
			pal_g_q[1] <= bc1_pkg::expand6(c1_n[10:5]);
			pal_b_q[1] <= bc1_pkg::expand5(c1_n[4:0]);
		end
		if (state_q == ST_PAL) begin
			if (mode3_q) begin
				pal_r_q[2] <= bc1_pkg::mid2(pal_r_q[0], pal_r_q[1]);
				pal_g_q[2] <= bc1_pkg::mid2(pal_g_q[0], pal_g_q[1]);
				pal_b_q[2] <= bc1_pkg::mid2(pal_b_q[0], pal_b_q[1]);
				pal_r_q[3] <= bc1_pkg::CHAN_MIN;
				pal_g_q[3] <= bc1_pkg::CHAN_MIN;
				pal_b_q[3] <= bc1_pkg::CHAN_MIN;
			end else begin
				pal_r_q[2] <= bc1_pkg::third(pal_r_q[0], pal_r_q[1]);
				pal_g_q[2] <= bc1_pkg::third(pal_g_q[0], pal_g_q[1]);
				pal_b_q[2] <= bc1_pkg::third(pal_b_q[0], pal_b_q[1]);
				pal_r_q[3] <= bc1_pkg::third(pal_r_q[1], pal_r_q[0]);
				pal_g_q[3] <= bc1_pkg::third(pal_g_q[1], pal_g_q[0]);
				pal_b_q[3] <= bc1_pkg::third(pal_b_q[1], pal_b_q[0]);
			end
		end
		idx_s1    <= cnt_q;
		idx_s2    <= idx_s1;
		transp_s2 <= mode3_q && (rdata_s1.alpha < thr_q);
		for (int k = 0; k < bc1_pkg::NUM_ENTRIES; k++) begin
			dist_s2[k] <= dist_now[k];
		end
		if (valid_s2) begin
			sel_q[{idx_s2, 1'b0} +: bc1_pkg::SEL_W] <= pick;
		end
		if (load_out) begin
			out_q.color_a       <= opaque_q ? c0_q : '0;
			out_q.color_b       <= opaque_q ? c1_q : '0;
			out_q.selector_bits <= opaque_q ? sel_q : '1;
		end
	end

endmodule

// ----- design/bc1_block_encoder.sv -----
// Top level of the BC1 block encoder: threshold register, pixel RAM, front end, queue, back end.
// Pixels of a 4x4 block enter in row-major order, one per cycle, into one of two RAM banks;
// the input stalls only while both banks hold blocks that the back end has not yet read.
// After the sixteenth pixel the block is queued, and the back end works through it in order:
// it registers the endpoints, builds the palette, reads the sixteen pixels through the single
// RAM read port, drains the two-stage distance pipeline and loads the output register.
// The back end works on one block at a time, while the front end takes the next block's
// pixels into the other bank; a stalled output holds the back end in its last step.
// The alpha threshold (reset 128) may be written between blocks or between pixels;
// the transparent index uses the value current at the block's last pixel.
module bc1_block_encoder (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [bc1_pkg::CHAN_W-1:0] cfg_data,
	input  logic                       pixel_valid,
	output logic                       pixel_stall,
	input  bc1_pkg::pixel_t            pixel,
	output logic                       block_valid,
	input  logic                       block_stall,
	output bc1_pkg::block_t            block
);

	logic [bc1_pkg::CHAN_W-1:0] alpha_threshold_q;
	bc1_pkg::ram_wr_t           ram_wr;
	bc1_pkg::ram_rd_t           ram_rd;
	bc1_pkg::pixel_t            rdata_s1;
	bc1_pkg::bank_rel_t         rel;
	bc1_pkg::desc_t             push_desc, head;
	bc1_pkg::queue_stat_t       q_stat;
	logic                       q_push, q_pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_threshold_q <= bc1_pkg::THRESHOLD_RESET;
		end else if (cfg_valid && cfg_ready) begin
			alpha_threshold_q <= cfg_data;
		end
	end

	bc1_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.pixel_valid (pixel_valid),
		.pixel_stall (pixel_stall),
		.pixel       (pixel),
		.threshold   (alpha_threshold_q),
		.rel         (rel),
		.ram_wr      (ram_wr),
		.push        (q_push),
		.desc        (push_desc)
	);

	bc1_ram #(
		.WIDTH (bc1_pkg::PIXEL_W),
		.DEPTH (bc1_pkg::RAM_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_wr.en),
		.waddr (ram_wr.addr),
		.wdata (ram_wr.data),
		.re    (ram_rd.en),
		.raddr (ram_rd.addr),
		.rdata (rdata_s1)
	);

	bc1_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (push_desc),
		.pop       (q_pop),
		.head      (head),
		.stat      (q_stat)
	);

	bc1_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_stat      (q_stat),
		.head        (head),
		.pop         (q_pop),
		.ram_rd      (ram_rd),
		.rdata_s1    (rdata_s1),
		.rel         (rel),
		.block_valid (block_valid),
		.block_stall (block_stall),
		.block       (block)
	);

	// A block request never arrives while the queue is full.
	a_queue_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_stat.full)
		else $error("block request pushed into a full queue");

	// The front end never writes the bank that the back end is reading.
	a_banks_apart: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_wr.en && ram_rd.en) |->
		(ram_wr.addr[bc1_pkg::RAM_AW-1:bc1_pkg::CNT_W] !=
		 ram_rd.addr[bc1_pkg::RAM_AW-1:bc1_pkg::CNT_W]))
		else $error("pixel write and read hit the same bank");

	// A bank is released only while a block request is being worked on, never while idle.
	a_release_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rel.valid |-> !q_pop)
		else $error("bank released in the same cycle a new block is taken");

endmodule
